[rtl/swstat_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Shared constants, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package swstat_pkg;

  localparam int WINDOW_DEF = 10;

  localparam int SAMPLE_W = 8;
  localparam int FILL_W   = 4;
  localparam int VAR_W    = 23;
  localparam int SIG_W    = 16;
  localparam int TREND_W  = 2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 80;

  localparam logic [TREND_W-1:0] TREND_UP   = 2'b01;
  localparam logic [TREND_W-1:0] TREND_FLAT = 2'b00;
  localparam logic [TREND_W-1:0] TREND_DOWN = 2'b11;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic mul1;
    logic mul2;
    logic div_mean_start;
    logic div_var_start;
    logic div_step;
    logic mean_latch;
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic few_samples;
  } sts_t;

endpackage

[rtl/sliding_window_statistics.sv]
// Each result passes through the window scan of up to 10 samples (the default window), the
// shared one-bit-per-cycle divider and the square root.
// Flow: the next sample is taken while a result waits, but a finished result holds the
// input closed until the previous one has left.
// A lone first sample skips the variance divide and the square root.
// Reset (rst_n, synchronous, active low) empties the window and clears the handshake state.
// ----------------------------------------------------------------------------
// Sliding window statistics
// Minimum, maximum, spread, mean, variance, deviation and trend over recent samples.
// ----------------------------------------------------------------------------
module sliding_window_statistics #(
  parameter int WINDOW = swstat_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swstat_pkg::IN_DATA_W-1:0]    in_tdata,  // sample[7:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // fill_count[3:0], min_sample[11:4], max_sample[19:12], spread[27:20], mean[35:28],
  // variance_q8[58:36], sigma_q8[74:59], trend[76:75], zero[79:77]
  output logic [swstat_pkg::OUT_DATA_W-1:0]   out_tdata
);

  swstat_pkg::cmd_t cmd;
  swstat_pkg::sts_t sts;
  logic [$clog2(WINDOW)-1:0] scan_idx;

  logic [swstat_pkg::FILL_W-1:0]   fill_count;
  logic [swstat_pkg::SAMPLE_W-1:0] min_sample, max_sample, spread, mean;
  logic [swstat_pkg::VAR_W-1:0]    variance_q8;
  logic [swstat_pkg::SIG_W-1:0]    sigma_q8;
  logic [swstat_pkg::TREND_W-1:0]  trend;

  swstat_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .scan_idx  (scan_idx)
  );

  swstat_dp #(.WINDOW(WINDOW)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .scan_idx    (scan_idx),
    .sample      (in_tdata[7:0]),
    .sts         (sts),
    .fill_count  (fill_count),
    .min_sample  (min_sample),
    .max_sample  (max_sample),
    .spread      (spread),
    .mean        (mean),
    .variance_q8 (variance_q8),
    .sigma_q8    (sigma_q8),
    .trend       (trend)
  );

  assign out_tdata = {3'b000, trend, sigma_q8, variance_q8, mean, spread,
                      max_sample, min_sample, fill_count};

endmodule

[rtl/swstat_ctrl.sv]
// ----------------------------------------------------------------------------
// Sliding window statistics controller
// Sequences the scan, the multiplies, the shared divider and the square root.
// ----------------------------------------------------------------------------
module swstat_ctrl #(
  parameter int WINDOW = swstat_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  swstat_pkg::sts_t    sts,
  output swstat_pkg::cmd_t    cmd,
  output logic [$clog2(WINDOW)-1:0] scan_idx
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = 8 + CW;
  localparam int NW  = 16 + 2 * CW;
  localparam int DVW = NW + 16;
  localparam int SQW = DVW + (DVW % 2);
  localparam int RTW = SQW / 2;
  localparam int STW = $clog2(DVW + 1);
  localparam int IW  = $clog2(WINDOW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_MDIV = 3'd4;
  localparam logic [2:0] ST_MLAT = 3'd5;
  localparam logic [2:0] ST_VDIV = 3'd6;
  localparam logic [2:0] ST_SQRT = 3'd7;

  logic [2:0]     state_r, state_nxt;
  logic [STW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           sq_pend_r, sq_pend_nxt;
  logic           done_pend_r, done_pend_nxt;

  assign in_ready  = (state_r == ST_IDLE) && !done_pend_r;
  assign out_valid = out_valid_r;
  assign scan_idx  = cnt_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sq_pend_nxt   = sq_pend_r;
    done_pend_nxt = done_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (done_pend_r) begin
          if (!out_valid_r || out_ready) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            done_pend_nxt = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2           = 1'b1;
        cmd.div_mean_start = 1'b1;
        cnt_nxt            = '0;
        state_nxt          = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STW'(SW - 1)) begin
          state_nxt = ST_MLAT;
        end
      end
      ST_MLAT: begin
        cmd.mean_latch = 1'b1;
        cnt_nxt        = '0;
        if (sts.few_samples) begin
          done_pend_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.div_var_start = 1'b1;
          state_nxt         = ST_VDIV;
        end
      end
      ST_VDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STW'(DVW - 1)) begin
          cnt_nxt     = '0;
          sq_pend_nxt = 1'b1;
          state_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_pend_r) begin
          cmd.sqrt_start = 1'b1;
          sq_pend_nxt    = 1'b0;
        end else begin
          cmd.sqrt_step = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == STW'(RTW - 1)) begin
            done_pend_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sq_pend_r   <= 1'b0;
      done_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sq_pend_r   <= sq_pend_nxt;
      done_pend_r <= done_pend_nxt;
    end
  end

endmodule

[rtl/swstat_dp.sv]
// ----------------------------------------------------------------------------
// Sliding window statistics datapath
// Sample window, scan accumulators, shared restoring divider and square root.
// ----------------------------------------------------------------------------
module swstat_dp #(
  parameter int WINDOW = swstat_pkg::WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  swstat_pkg::cmd_t                       cmd,
  input  logic [$clog2(WINDOW)-1:0]              scan_idx,
  input  logic [swstat_pkg::SAMPLE_W-1:0]        sample,
  output swstat_pkg::sts_t                       sts,
  output logic [swstat_pkg::FILL_W-1:0]          fill_count,
  output logic [swstat_pkg::SAMPLE_W-1:0]        min_sample,
  output logic [swstat_pkg::SAMPLE_W-1:0]        max_sample,
  output logic [swstat_pkg::SAMPLE_W-1:0]        spread,
  output logic [swstat_pkg::SAMPLE_W-1:0]        mean,
  output logic [swstat_pkg::VAR_W-1:0]           variance_q8,
  output logic [swstat_pkg::SIG_W-1:0]           sigma_q8,
  output logic [swstat_pkg::TREND_W-1:0]         trend
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int IW  = $clog2(WINDOW);
  localparam int SW  = 8 + CW;
  localparam int QW  = 16 + CW;
  localparam int NW  = 16 + 2 * CW;
  localparam int DW  = 2 * CW;
  localparam int DVW = NW + 16;
  localparam int SQW = DVW + (DVW % 2);
  localparam int RTW = SQW / 2;
  localparam int RW  = RTW + 2;
  localparam int VQW = DVW - 8;

  logic [7:0]     win_r [WINDOW];
  logic [CW-1:0]  count_r;
  logic [7:0]     newest_r, prev_r;
  logic [7:0]     mn_r, mx_r;
  logic [SW-1:0]  sum_r;
  logic [QW-1:0]  sumsq_r;
  logic [NW-1:0]  p1_r, p2_r;
  logic [DW-1:0]  den_r;
  logic [DVW-1:0] dvd_r, quo_r;
  logic [DW-1:0]  rem_r;
  logic [7:0]     mean_r;
  logic [SQW-1:0] sqv_r;
  logic [RTW-1:0] root_r;
  logic [RW-1:0]  srem_r;

  logic [7:0]     scan_v;
  logic [DW:0]    div_t;
  logic [RW-1:0]  sq_t, sq_trial;
  logic [NW-1:0]  num;
  logic [VQW-1:0] var_full;

  assign scan_v          = win_r[scan_idx];
  assign sts.scan_last   = (CW'(scan_idx) == (count_r - 1'b1));
  assign sts.few_samples = (count_r < CW'(2));
  assign div_t           = {rem_r, dvd_r[DVW-1]};
  assign sq_t            = {srem_r[RW-3:0], sqv_r[SQW-1:SQW-2]};
  assign sq_trial        = {root_r, 2'b01};
  assign num             = p1_r - p2_r;
  assign var_full        = quo_r[DVW-1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load && (count_r != CW'(WINDOW))) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (count_r == CW'(WINDOW)) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WINDOW-1] <= sample;
      end else begin
        win_r[count_r[IW-1:0]] <= sample;
      end
      prev_r   <= newest_r;
      newest_r <= sample;
      mn_r     <= 8'hFF;
      mx_r     <= 8'h00;
      sum_r    <= '0;
      sumsq_r  <= '0;
    end
    if (cmd.scan_step) begin
      if (scan_v < mn_r) begin
        mn_r <= scan_v;
      end
      if (scan_v > mx_r) begin
        mx_r <= scan_v;
      end
      sum_r   <= sum_r + SW'(scan_v);
      sumsq_r <= sumsq_r + QW'(16'(scan_v * scan_v));
    end
    if (cmd.mul1) begin
      p1_r <= NW'(count_r * sumsq_r);
    end
    if (cmd.mul2) begin
      p2_r <= NW'(sum_r * sum_r);
    end
    if (cmd.div_mean_start) begin
      dvd_r <= {sum_r, {(DVW-SW){1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      den_r <= DW'(count_r);
    end
    if (cmd.div_var_start) begin
      dvd_r <= {num, 16'h0000};
      rem_r <= '0;
      quo_r <= '0;
      den_r <= DW'(count_r * (count_r - 1'b1));
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVW-2:0], 1'b0};
      if (div_t >= {1'b0, den_r}) begin
        rem_r <= DW'(div_t - {1'b0, den_r});
        quo_r <= {quo_r[DVW-2:0], 1'b1};
      end else begin
        rem_r <= div_t[DW-1:0];
        quo_r <= {quo_r[DVW-2:0], 1'b0};
      end
    end
    if (cmd.mean_latch) begin
      mean_r <= quo_r[7:0];
      if (!cmd.div_var_start) begin
        den_r <= '0;
      end
    end
    if (cmd.sqrt_start) begin
      sqv_r  <= SQW'(quo_r);
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sqv_r <= {sqv_r[SQW-3:0], 2'b00};
      if (sq_t >= sq_trial) begin
        srem_r <= sq_t - sq_trial;
        root_r <= {root_r[RTW-2:0], 1'b1};
      end else begin
        srem_r <= sq_t;
        root_r <= {root_r[RTW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      fill_count <= swstat_pkg::FILL_W'(count_r);
      min_sample <= mn_r;
      max_sample <= mx_r;
      spread     <= mx_r - mn_r;
      mean       <= mean_r;
      if (sts.few_samples) begin
        variance_q8 <= '0;
        sigma_q8    <= '0;
        trend       <= swstat_pkg::TREND_FLAT;
      end else begin
        if (var_full > VQW'(8388607)) begin
          variance_q8 <= 23'h7FFFFF;
        end else begin
          variance_q8 <= var_full[swstat_pkg::VAR_W-1:0];
        end
        if (root_r > RTW'(65535)) begin
          sigma_q8 <= 16'hFFFF;
        end else begin
          sigma_q8 <= root_r[swstat_pkg::SIG_W-1:0];
        end
        if (newest_r > prev_r) begin
          trend <= swstat_pkg::TREND_UP;
        end else if (newest_r < prev_r) begin
          trend <= swstat_pkg::TREND_DOWN;
        end else begin
          trend <= swstat_pkg::TREND_FLAT;
        end
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window statistics testbench
// Streams 8-bit samples into the block, predicts the window statistics of
// every request and compares each result as a whole, under random gaps,
// random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WIN       = swstat_pkg::WINDOW_DEF;
  localparam int WDOG_LIM  = 20000;
  localparam int LATENCY   = 200;

  typedef struct packed {
    logic [2:0]                     pad;
    logic [swstat_pkg::TREND_W-1:0] trend;
    logic [swstat_pkg::SIG_W-1:0]   sigma_q8;
    logic [swstat_pkg::VAR_W-1:0]   variance_q8;
    logic [7:0]                     mean;
    logic [7:0]                     spread;
    logic [7:0]                     max_sample;
    logic [7:0]                     min_sample;
    logic [swstat_pkg::FILL_W-1:0]  fill_count;
  } stats_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [swstat_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [swstat_pkg::OUT_DATA_W-1:0] out_tdata;

  logic [7:0] window_q[$];
  stats_t expected_stats[$];
  int fail_count;
  int idle_cycles;
  bit hold_off;
  bit stall_enable;

  sliding_window_statistics DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] one;
    root = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= root + one) begin
        v = v - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root;
  endfunction

  function automatic stats_t window_stats(input logic [7:0] s);
    stats_t r;
    logic [63:0] total, total_sq, num, den, v;
    logic [7:0] lo, hi;
    int n;
    if (window_q.size() == WIN) void'(window_q.pop_front());
    window_q.push_back(s);
    n = window_q.size();
    lo = 8'hFF;
    hi = 8'h00;
    total = 0;
    total_sq = 0;
    foreach (window_q[i]) begin
      if (window_q[i] < lo) lo = window_q[i];
      if (window_q[i] > hi) hi = window_q[i];
      total += 64'(window_q[i]);
      total_sq += 64'(window_q[i]) * 64'(window_q[i]);
    end
    r = '0;
    r.fill_count = 4'(n);
    r.min_sample = lo;
    r.max_sample = hi;
    r.spread = hi - lo;
    r.mean = 8'(total / 64'(n));
    r.trend = swstat_pkg::TREND_FLAT;
    if (n >= 2) begin
      num = 64'(n) * total_sq - total * total;
      den = 64'(n) * 64'(n - 1);
      v = (num * 256) / den;
      r.variance_q8 = (v > 64'h7FFFFF) ? 23'h7FFFFF : v[swstat_pkg::VAR_W-1:0];
      v = int_sqrt((num * 65536) / den);
      r.sigma_q8 = (v > 64'hFFFF) ? 16'hFFFF : v[swstat_pkg::SIG_W-1:0];
      if (window_q[n-1] > window_q[n-2]) r.trend = swstat_pkg::TREND_UP;
      else if (window_q[n-1] < window_q[n-2]) r.trend = swstat_pkg::TREND_DOWN;
    end
    return r;
  endfunction

  task automatic send_sample(input logic [7:0] s, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_stats.push_back(window_stats(s));
  endtask

  task automatic send_burst(input int count, input int mode);
    int burst;
    logic [7:0] s;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: s = 8'($urandom_range(0, 255));
        1: s = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        2: s = 8'(128 + $urandom_range(0, 6) - 3);
        default: s = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(240, 255));
      endcase
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        send_sample(s, $urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
      end else begin
        send_sample(s, 0);
      end
      burst--;
    end
  endtask

  task automatic test_directed_extremes();
    logic [7:0] seq[] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd1, 8'd128, 8'd127,
                          8'd170, 8'd85, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                          8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd7};
    foreach (seq[i]) send_sample(seq[i], 0);
  endtask

  task automatic test_random_samples();
    for (int k = 0; k < 50; k++) send_burst(30, k % 4);
  endtask

  task automatic test_output_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_sample(8'($urandom_range(0, 255)), 0);
    join
  endtask

  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!stall_enable) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 499) == 0) stall_enable <= ~stall_enable;
  end

  always @(posedge clk) begin
    stats_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        fail_count++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (got !== exp_s) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_s, got);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIM) begin
      $display("sliding_window_statistics regression: fail");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    stall_enable = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_output_backpressure();
    test_random_samples();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0) begin
      $display("sliding_window_statistics regression: pass");
    end else begin
      $display("sliding_window_statistics regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/swstat_pkg.sv
rtl/swstat_ctrl.sv
rtl/swstat_dp.sv
rtl/sliding_window_statistics.sv
tb/sv/tb_top.sv
